// ===== hw/rtl/efr_pkg.sv =====
// Shared types and constants for the escaped frame receiver.
`timescale 1ns / 1ps

package efr_pkg;

   // Command codes carried on the request channel
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_START_BYTE  = 2'd0;
   localparam logic [1:0] REG_END_BYTE    = 2'd1;
   localparam logic [1:0] REG_ESCAPE_BYTE = 2'd2;
   localparam logic [1:0] REG_IDLE_TICKS  = 2'd3;

   // Configuration reset values
   localparam logic [7:0] RST_START_BYTE  = 8'd2;
   localparam logic [7:0] RST_END_BYTE    = 8'd3;
   localparam logic [7:0] RST_ESCAPE_BYTE = 8'd16;
   localparam logic [7:0] RST_IDLE_TICKS  = 8'd10;

   // One result beat as it travels from the front end through the queue
   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] frame_length;
      logic [7:0] frames_done;
      logic       frame_published;
      logic       overflow_seen;
   } efr_rsp_type;

endpackage

// ===== hw/rtl/efr_if.sv =====
// Request and response channel interfaces of the escaped frame receiver.
`timescale 1ns / 1ps

interface efr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;
   logic [7:0] read_index;

   modport source (output valid, output cmd, output rx_byte, output read_index,
                   input ready);
   modport sink (input valid, input cmd, input rx_byte, input read_index,
                 output ready);
endinterface

interface efr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] frame_length;
   logic [7:0] frames_done;
   logic       frame_published;
   logic       overflow_seen;

   modport source (output valid, output read_data, output frame_length,
                   output frames_done, output frame_published, output overflow_seen,
                   input ready);
   modport sink (input valid, input read_data, input frame_length,
                 input frames_done, input frame_published, input overflow_seen,
                 output ready);
endinterface

// ===== hw/rtl/efr_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module efr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/efr_front.sv =====
// Front end: configuration, frame tracking, two-bank frame buffer and read issue.
`timescale 1ns / 1ps

module efr_front
   import efr_pkg::*;
#(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        accept,
   input  logic [1:0]  cmd,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  read_index,
   output logic        push_valid,
   output efr_rsp_type push_rsp
);

   localparam int CAP       = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;
   localparam int AW        = $clog2(CAP);
   localparam int FW        = $clog2(CAP + 1);
   localparam int RAM_DEPTH = 2 * (2 ** AW);
   localparam logic [FW-1:0] CAP_FILL = FW'(CAP);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_BODY   = 4'b0010,
      PH_ESC    = 4'b0100,
      PH_CLOSED = 4'b1000
   } efr_phase_type;

   logic [7:0]    start_ff, end_ff, escape_ff, idle_ff;
   efr_phase_type phase_ff, phase_in;
   logic [7:0]    timer_ff, timer_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          bank_ff, bank_in;
   logic          published;
   logic          keep_byte;

   logic          wr_en;
   logic [AW:0]   wr_addr;
   logic          rd_en;
   logic [AW:0]   rd_addr;
   logic [8:0]    rd_offset;
   logic [7:0]    rd_data;

   logic          job_valid_ff;
   logic          job_hit_ff;
   efr_rsp_type   job_ff;

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      bank_in   = bank_ff;
      published = 1'b0;
      keep_byte = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = {bank_ff, fill_ff[AW-1:0]};
      if (accept) begin
         case (cmd)
            CMD_BYTE: begin
               if (timer_ff == 8'd0 && rx_byte == start_ff) begin
                  // open a frame: start byte lands at offset zero
                  fill_in  = FW'(1);
                  ovf_in   = 1'b0;
                  timer_in = idle_ff;
                  wr_en    = 1'b1;
                  wr_addr  = {bank_ff, AW'(0)};
                  phase_in = PH_BODY;
               end else if (phase_ff == PH_BODY) begin
                  timer_in = idle_ff;
                  if (rx_byte == escape_ff) begin
                     phase_in = PH_ESC;
                  end else begin
                     keep_byte = 1'b1;
                     if (rx_byte == end_ff) begin
                        phase_in = PH_CLOSED;
                     end
                  end
               end else if (phase_ff == PH_ESC) begin
                  timer_in  = idle_ff;
                  keep_byte = 1'b1;
                  phase_in  = PH_BODY;
               end
            end
            CMD_TICK: begin
               if (timer_ff != 8'd0) begin
                  timer_in = timer_ff - 8'd1;
               end else if (phase_ff == PH_CLOSED) begin
                  phase_in = PH_IDLE;
                  if (fill_ff > FW'(2)) begin
                     // swap banks instead of copying the payload
                     len_in    = 8'(fill_ff - FW'(2));
                     count_in  = count_ff + 8'd1;
                     published = 1'b1;
                     bank_in   = ~bank_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (keep_byte) begin
         if (fill_ff < CAP_FILL) begin
            wr_en   = 1'b1;
            fill_in = fill_ff + FW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // payload byte i sits one past it in the published bank (start byte dropped)
   assign rd_en     = accept && (cmd == CMD_READ);
   assign rd_offset = {1'b0, read_index} + 9'd1;
   assign rd_addr   = {~bank_ff, rd_offset[AW-1:0]};

   efr_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= RST_START_BYTE;
         end_ff       <= RST_END_BYTE;
         escape_ff    <= RST_ESCAPE_BYTE;
         idle_ff      <= RST_IDLE_TICKS;
         phase_ff     <= PH_IDLE;
         timer_ff     <= 8'd0;
         fill_ff      <= '0;
         len_ff       <= 8'd0;
         count_ff     <= 8'd0;
         ovf_ff       <= 1'b0;
         bank_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_START_BYTE:  start_ff  <= csr_wdata;
               REG_END_BYTE:    end_ff    <= csr_wdata;
               REG_ESCAPE_BYTE: escape_ff <= csr_wdata;
               REG_IDLE_TICKS:  idle_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         bank_ff      <= bank_in;
         job_valid_ff <= accept;
      end
   end

   // result fields are registered alongside the registered RAM read
   always_ff @(posedge clock) begin
      if (accept) begin
         job_hit_ff             <= rd_en && (read_index < len_ff);
         job_ff.read_data       <= 8'd0;
         job_ff.frame_length    <= len_in;
         job_ff.frames_done     <= count_in;
         job_ff.frame_published <= published;
         job_ff.overflow_seen   <= ovf_in;
      end
   end

   always_comb begin
      push_rsp           = job_ff;
      push_rsp.read_data = job_hit_ff ? rd_data : 8'd0;
   end

   assign push_valid = job_valid_ff;

endmodule

// ===== hw/rtl/efr_back.sv =====
// Back end: short result queue and output register toward the response channel.
`timescale 1ns / 1ps

module efr_back
   import efr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  efr_rsp_type push_rsp,
   output logic        room,
   output logic        out_valid,
   input  logic        out_ready,
   output efr_rsp_type out_rsp
);

   localparam int QD = 4;
   localparam int PW = $clog2(QD);
   localparam int CW = $clog2(QD + 2);

   efr_rsp_type   q_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          out_valid_ff, out_valid_in;
   efr_rsp_type   out_rsp_ff;
   logic          pop;

   // leave a slot for the beat still waiting on its RAM read
   assign room = (count_ff + CW'(push_valid)) < CW'(QD);
   assign pop  = (count_ff != '0) && (!out_valid_ff || out_ready);

   always_comb begin
      wr_ptr_in    = push_valid ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in     = count_ff + CW'(push_valid) - CW'(pop);
      out_valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         q_ff[wr_ptr_ff] <= push_rsp;
      end
      if (pop) begin
         out_rsp_ff <= q_ff[rd_ptr_ff];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule

// ===== hw/rtl/escaped_frame_receiver.sv =====
// Top level of the escaped frame receiver: front end, result queue and channels.
`timescale 1ns / 1ps

//  Channel   Dir   Carries
//  req_bus   in    cmd, rx_byte, read_index (byte, tick or payload read)
//  rsp_bus   out   read_data, frame_length, frames_done, frame_published,
//                  overflow_seen (one beat per request beat)
//  csr_*     in    write enable, register index, 8-bit write data
//
//  One request beat per cycle while req_bus is ready; its response beat
//  passes the buffer RAM read with the state update, the result queue
//  write and the output register, and leaves when rsp_bus is ready.
//  Throughput is one beat per cycle while ready, set by the single frame-state update.
//  Synchronous active-high reset; no clearing pass, the frame buffer is
//  only ever read where it was written.
//  A stalled rsp_bus fills the four-entry result queue, then drops
//  req_bus.ready; the back end keeps one slot free for the in-flight read.

module escaped_frame_receiver
   import efr_pkg::*;
#(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   efr_req_if.sink    req_bus,
   efr_rsp_if.source  rsp_bus,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int CAP = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;
   localparam logic [7:0] MAX_LEN = 8'(CAP - 2);

   logic        req_fire;
   logic        room;
   logic        push_valid;
   efr_rsp_type push_rsp;
   logic        out_valid;
   efr_rsp_type out_rsp;

   // a beat is taken whenever the queue can absorb it
   assign req_bus.ready = room;
   assign req_fire      = req_bus.valid && room;

   // front end: advance the frame state and issue buffer reads
   efr_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (req_fire),
      .cmd        (req_bus.cmd),
      .rx_byte    (req_bus.rx_byte),
      .read_index (req_bus.read_index),
      .push_valid (push_valid),
      .push_rsp   (push_rsp)
   );

   // back end: hold results until the response side takes them
   efr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rsp   (push_rsp),
      .room       (room),
      .out_valid  (out_valid),
      .out_ready  (rsp_bus.ready),
      .out_rsp    (out_rsp)
   );

   assign rsp_bus.valid           = out_valid;
   assign rsp_bus.read_data       = out_rsp.read_data;
   assign rsp_bus.frame_length    = out_rsp.frame_length;
   assign rsp_bus.frames_done     = out_rsp.frames_done;
   assign rsp_bus.frame_published = out_rsp.frame_published;
   assign rsp_bus.overflow_seen   = out_rsp.overflow_seen;

   // every taken beat reaches the queue in the following cycle
   a_fire_pushes: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> push_valid)
      else $error("request beat did not reach the result queue");

   // a published frame carries a payload that fits the buffer
   a_pub_length: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_rsp.frame_published |->
         push_rsp.frame_length != 8'd0 && push_rsp.frame_length <= MAX_LEN)
      else $error("published frame length out of range");

   // the queue never takes a beat that was not requested
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> !push_valid)
      else $error("result pushed without a request beat");

endmodule

// ===== dv/tb_escaped_frame_receiver.sv =====
// Self-checking testbench for the escaped frame receiver: random framed traffic, scoreboard.
`timescale 1ns / 1ps

module tb_escaped_frame_receiver;
   import efr_pkg::*;

   // The spare command code has no name in the package; it must change nothing.
   localparam logic [1:0] CMD_SPARE = 2'd3;
   // Assembly capacity for the default buffer depth.
   localparam int unsigned FRAME_CAP = 256;
   // Response beats before the long receiver hold-off, and its length in cycles.
   localparam int unsigned HOLD_AT_BEAT = 700;
   localparam int unsigned HOLD_CYCLES = 400;
   // Rough beat count for each random phase.
   localparam int unsigned PHASE_BEATS = 110;

   typedef enum logic [1:0] {RX_IDLE, RX_BODY, RX_ESCAPED, RX_CLOSED} rx_phase_type;

   // Frame decoder prediction plus the queue of status beats still owed by the block.
   class frame_decode_board_type;
      logic [7:0]   start_code, end_code, escape_code, idle_reload;
      rx_phase_type phase;
      logic [7:0]   silence_left;
      int unsigned  fill;
      logic [7:0]   assembly [FRAME_CAP];
      logic [7:0]   payload [FRAME_CAP];
      logic [7:0]   payload_len, frame_count;
      logic         overflow;
      efr_rsp_type  status_due [$];
      int unsigned  mismatches;

      function new();
         start_code   = RST_START_BYTE;
         end_code     = RST_END_BYTE;
         escape_code  = RST_ESCAPE_BYTE;
         idle_reload  = RST_IDLE_TICKS;
         phase        = RX_IDLE;
         silence_left = '0;
         fill         = 0;
         payload_len  = '0;
         frame_count  = '0;
         overflow     = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [7:0] value);
         case (index)
            REG_START_BYTE:  start_code = value;
            REG_END_BYTE:    end_code = value;
            REG_ESCAPE_BYTE: escape_code = value;
            REG_IDLE_TICKS:  idle_reload = value;
            default: ;
         endcase
      endfunction

      // Keep a byte in the assembly store, or flag it as dropped past capacity.
      function void store_byte(logic [7:0] value);
         if (fill < FRAME_CAP) begin
            assembly[fill] = value;
            fill++;
         end else begin
            overflow = 1'b1;
         end
      endfunction

      // Advance the decoder by one accepted request beat and queue the status it owes.
      function void note_beat(logic [1:0] cmd, logic [7:0] rx_byte, logic [7:0] read_index);
         efr_rsp_type due;
         due = '0;
         case (cmd)
            CMD_BYTE: begin
               if (silence_left == 0 && rx_byte == start_code) begin
                  fill = 0;
                  overflow = 1'b0;
                  silence_left = idle_reload;
                  store_byte(rx_byte);
                  phase = RX_BODY;
               end else if (phase == RX_BODY) begin
                  silence_left = idle_reload;
                  if (rx_byte == escape_code) begin
                     phase = RX_ESCAPED;
                  end else if (rx_byte == end_code) begin
                     store_byte(rx_byte);
                     phase = RX_CLOSED;
                  end else begin
                     store_byte(rx_byte);
                  end
               end else if (phase == RX_ESCAPED) begin
                  silence_left = idle_reload;
                  store_byte(rx_byte);
                  phase = RX_BODY;
               end
            end
            CMD_TICK: begin
               if (silence_left != 0) begin
                  silence_left--;
               end else if (phase == RX_CLOSED) begin
                  phase = RX_IDLE;
                  if (fill > 2) begin
                     for (int i = 0; i < fill - 2; i++) payload[i] = assembly[i + 1];
                     payload_len = 8'(fill - 2);
                     frame_count++;
                     due.frame_published = 1'b1;
                  end
               end
            end
            CMD_READ: begin
               if (read_index < payload_len) due.read_data = payload[read_index];
            end
            default: ;
         endcase
         due.frame_length  = payload_len;
         due.frames_done   = frame_count;
         due.overflow_seen = overflow;
         status_due.push_back(due);
      endfunction

      // Compare one response beat with the oldest status owed.
      function void check_beat(efr_rsp_type got);
         efr_rsp_type want;
         if (status_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response beat, expected none, actual %h", $time, got);
            return;
         end
         want = status_due.pop_front();
         if (want != got) begin
            mismatches++;
            $display("%0t: read_data exp %0h act %0h | frame_length exp %0d act %0d",
                     $time, want.read_data, got.read_data,
                     want.frame_length, got.frame_length);
            $display("%0t:   frames_done exp %0d act %0d | published exp %b act %b",
                     $time, want.frames_done, got.frames_done,
                     want.frame_published, got.frame_published);
            $display("%0t:   overflow exp %b act %b",
                     $time, want.overflow_seen, got.overflow_seen);
         end
      endfunction

      function int unsigned pending();
         return status_due.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   efr_req_if req_bus ();
   efr_rsp_if rsp_bus ();

   frame_decode_board_type board = new();

   int unsigned beats_sent;
   int unsigned beats_taken;
   int          send_run;
   int          take_run;

   escaped_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, 8 ns period.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Draw a random wait; every so often start a run of back-to-back beats.
   function automatic int draw_wait(ref int busy_run);
      if (busy_run > 0) begin
         busy_run--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         busy_run = $urandom_range(16, 64);
         return 0;
      end
      return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Offer one request beat after a random gap; hold it until the block takes it.
   // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
   task automatic drive_beat(input logic [1:0] cmd, input logic [7:0] rx_byte,
                             input logic [7:0] read_index);
      int gap;
      gap = draw_wait(send_run);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.rx_byte    <= rx_byte;
      req_bus.read_index <= read_index;
      do @(posedge clock); while (!req_bus.ready);
      board.note_beat(cmd, rx_byte, read_index);
      beats_sent++;
   endtask

   // Write one configuration register; the caller drops the write enable afterwards.
   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(index, value);
   endtask

   // Stop offering, wait for every owed response, then let the pipeline drain.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Tick until the silence timer is zero, then one more tick to publish a closed frame.
   task automatic run_quiet();
      while (board.silence_left != 0) drive_beat(CMD_TICK, 8'($urandom), 8'($urandom));
      drive_beat(CMD_TICK, 8'($urandom), 8'($urandom));
   endtask

   // Send one frame: start, payload with escapes around the control codes, end unless leave_open.
   task automatic send_frame(input int unsigned payload_count, input bit leave_open);
      logic [7:0] value;
      // Let the line go quiet so the start byte actually opens a frame.
      while (board.silence_left != 0) drive_beat(CMD_TICK, 8'($urandom), 8'($urandom));
      drive_beat(CMD_BYTE, board.start_code, 8'($urandom));
      for (int unsigned k = 0; k < payload_count; k++) begin
         case ($urandom_range(0, 7))
            0:       value = board.start_code;
            1:       value = board.end_code;
            2:       value = board.escape_code;
            default: value = 8'($urandom);
         endcase
         // Escape control codes; a start byte is sometimes sent raw as plain data.
         if (value == board.end_code || value == board.escape_code ||
             (value == board.start_code && $urandom_range(0, 1) == 0))
            drive_beat(CMD_BYTE, board.escape_code, 8'($urandom));
         drive_beat(CMD_BYTE, value, 8'($urandom));
         // Drop in a stray tick now and then while the frame is open.
         if ($urandom_range(0, 39) == 0) drive_beat(CMD_TICK, 8'($urandom), 8'($urandom));
      end
      if (!leave_open) drive_beat(CMD_BYTE, board.end_code, 8'($urandom));
   endtask

   // Response side: random stalls, one long hold-off so the block backs up.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      beats_taken   = 0;
      take_run      = 0;
      @(negedge reset);
      forever begin
         stall = draw_wait(take_run);
         // Hold off long enough to fill the result queue and stall the request side.
         if (beats_taken == HOLD_AT_BEAT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         board.check_beat({rsp_bus.read_data, rsp_bus.frame_length, rsp_bus.frames_done,
                           rsp_bus.frame_published, rsp_bus.overflow_seen});
         beats_taken++;
      end
   end

   // Request side: reset, directed beats, then random phases under several settings.
   initial begin
      logic [7:0]  s_code, e_code, x_code, i_ticks;
      int unsigned stop_at;
      int unsigned len;
      bit          open_end;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_BYTE;
      req_bus.rx_byte    = '0;
      req_bus.read_index = '0;
      csr_we             = 1'b0;
      csr_index          = REG_START_BYTE;
      csr_wdata          = '0;
      beats_sent         = 0;
      send_run           = 0;
      reset              = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset codes, short timeout so frames publish quickly.
      write_register(REG_IDLE_TICKS, 8'd1);
      csr_we <= 1'b0;
      drive_beat(CMD_BYTE, 8'h55, 8'h00);            // byte outside a frame: ignored
      drive_beat(CMD_READ, 8'h00, 8'h00);            // read before any frame
      drive_beat(CMD_SPARE, 8'hFF, 8'hFF);           // unused command
      drive_beat(CMD_BYTE, RST_START_BYTE, 8'h00);   // open
      drive_beat(CMD_BYTE, 8'h00, 8'h00);
      drive_beat(CMD_BYTE, RST_START_BYTE, 8'h00);   // start inside frame is data
      drive_beat(CMD_BYTE, RST_ESCAPE_BYTE, 8'h00);
      drive_beat(CMD_BYTE, RST_END_BYTE, 8'h00);     // escaped end is data
      drive_beat(CMD_BYTE, 8'hFF, 8'h00);
      drive_beat(CMD_BYTE, RST_END_BYTE, 8'h00);     // close
      drive_beat(CMD_TICK, 8'h00, 8'h00);
      drive_beat(CMD_TICK, 8'h00, 8'h00);            // publish four payload bytes
      drive_beat(CMD_READ, 8'h00, 8'd0);
      drive_beat(CMD_READ, 8'h00, 8'd3);
      drive_beat(CMD_READ, 8'h00, 8'd4);             // one past the payload
      drive_beat(CMD_READ, 8'h00, 8'd255);
      drive_beat(CMD_BYTE, RST_START_BYTE, 8'h00);   // short frame: start then end
      drive_beat(CMD_BYTE, RST_END_BYTE, 8'h00);
      drive_beat(CMD_TICK, 8'h00, 8'h00);
      drive_beat(CMD_TICK, 8'h00, 8'h00);            // returns to idle, no publish
      drive_beat(CMD_TICK, 8'h00, 8'h00);
      drive_beat(CMD_BYTE, RST_END_BYTE, 8'h00);     // end byte outside a frame

      // Random phases; each starts from an idle block with new register values.
      for (int p = 0; p < 8; p++) begin
         settle();
         case (p)
            0: begin
               s_code = 8'h00; e_code = 8'hFF; x_code = 8'h7D; i_ticks = 8'd0;
            end
            1: begin
               s_code = 8'hFF; e_code = 8'h00; x_code = 8'h80; i_ticks = 8'd255;
            end
            7: begin
               // Draw from a tiny set so the control codes may collide.
               s_code = 8'($urandom_range(0, 2));
               e_code = 8'($urandom_range(0, 2));
               x_code = 8'($urandom_range(0, 2));
               i_ticks = 8'($urandom_range(0, 3));
            end
            default: begin
               s_code = 8'($urandom);
               do e_code = 8'($urandom); while (e_code == s_code);
               do x_code = 8'($urandom); while (x_code == s_code || x_code == e_code);
               i_ticks = 8'($urandom_range(0, 6));
            end
         endcase
         write_register(REG_START_BYTE, s_code);
         write_register(REG_END_BYTE, e_code);
         write_register(REG_ESCAPE_BYTE, x_code);
         write_register(REG_IDLE_TICKS, i_ticks);
         csr_we <= 1'b0;

         // Overrun the assembly store once: the truncated frame must still publish.
         if (p == 3) begin
            send_frame(300, 1'b0);
            run_quiet();
            repeat (4) drive_beat(CMD_READ, 8'($urandom), 8'($urandom));
         end

         stop_at = beats_sent + PHASE_BEATS;
         while (beats_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
               // Mostly short frames, a few long ones.
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 250)
                                                 : $urandom_range(0, 12);
               open_end = ($urandom_range(0, 11) == 0);
               send_frame(len, open_end);
               if (!open_end) begin
                  if ($urandom_range(0, 6) != 0) run_quiet();
                  else repeat ($urandom_range(1, 3)) drive_beat(CMD_TICK, 8'($urandom),
                                                                8'($urandom));
               end
               repeat ($urandom_range(0, 5))
                  drive_beat(CMD_READ, 8'($urandom),
                             ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, board.payload_len))
                                                          : 8'($urandom));
            end else begin
               // Noise: stray bytes, ticks, reads and the spare command.
               repeat ($urandom_range(1, 4))
                  drive_beat(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end
         end
      end

      // Stop offering, drain every owed beat, then report.
      settle();
      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a missing response ends the run here.
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/efr_pkg.sv
hw/rtl/efr_if.sv
hw/rtl/efr_ram.sv
hw/rtl/efr_front.sv
hw/rtl/efr_back.sv
hw/rtl/escaped_frame_receiver.sv
dv/tb_escaped_frame_receiver.sv
